// ===== src/fhst_pkg.sv =====
package fhst_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 4096;
    localparam int unsigned DEFAULT_VALUE_WIDTH = 32;

    localparam int unsigned HASH_W  = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned SLOT_W  = 12;
    localparam int unsigned DATA_W  = 32;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

    typedef enum logic [0:0] {
        OP_READ   = 1'b0,
        OP_INSERT = 1'b1
    } op_t;

    typedef struct packed {
        op_t               operation;
        logic [BYTE_W-1:0] key_byte;
        logic              key_last;
        logic [DATA_W-1:0] insert_value;
    } in_word_t;

    typedef struct packed {
        logic [HASH_W-1:0] key_hash;
        logic [SLOT_W-1:0] slot_index;
        logic [DATA_W-1:0] read_value;
        logic              found;
    } out_word_t;

    typedef struct packed {
        logic lookup;
        logic insert;
    } slot_cmd_t;

    // Multiply by the FNV prime 2^40 + 2^8 + 0xB3, modulo 2^64, as shifts and adds.
    function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
        fnv_mul = x + (x << 1) + (x << 4) + (x << 5) + (x << 7) + (x << 8) + (x << 40);
    endfunction

endpackage

// ===== src/fhst_hash_unit.sv =====
module fhst_hash_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  logic [fhst_pkg::BYTE_W-1:0]  key_byte,
    input  logic                         key_last,
    output logic [fhst_pkg::HASH_W-1:0]  hash_out
);
    import fhst_pkg::*;

    logic [HASH_W-1:0] running_hash_reg;
    logic [HASH_W-1:0] running_hash_next;

    assign hash_out = fnv_mul(running_hash_reg ^ {{(HASH_W-BYTE_W){1'b0}}, key_byte});

    always_comb begin
        running_hash_next = running_hash_reg;
        if (accept) begin
            running_hash_next = key_last ? FNV_BASIS : hash_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_hash_reg <= FNV_BASIS;
        end else begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule

// ===== src/fhst_slot_store.sv =====
module fhst_slot_store #(
    parameter int unsigned TABLE_DEPTH = fhst_pkg::DEFAULT_TABLE_DEPTH,
    parameter int unsigned VALUE_WIDTH = fhst_pkg::DEFAULT_VALUE_WIDTH,
    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  fhst_pkg::slot_cmd_t     cmd,
    input  logic [IDX_W-1:0]        addr,
    input  logic [VALUE_WIDTH-1:0]  wr_value,
    output logic [VALUE_WIDTH-1:0]  rd_value,
    output logic                    rd_valid,
    output logic                    busy
);
    import fhst_pkg::*;

    logic [VALUE_WIDTH-1:0] value_mem [TABLE_DEPTH];
    logic                   valid_mem [TABLE_DEPTH];

    logic [VALUE_WIDTH-1:0] rd_value_reg;
    logic                   rd_valid_reg;
    logic                   clearing_reg;
    logic                   clearing_next;
    logic [IDX_W-1:0]       clr_addr_reg;
    logic [IDX_W-1:0]       clr_addr_next;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(TABLE_DEPTH - 1);

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_ADDR) begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing_reg) begin
            valid_mem[clr_addr_reg] <= 1'b0;
        end else if (cmd.insert) begin
            valid_mem[addr] <= 1'b1;
        end
        if (cmd.lookup) begin
            rd_valid_reg <= valid_mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            value_mem[addr] <= wr_value;
        end
        if (cmd.lookup) begin
            rd_value_reg <= value_mem[addr];
        end
    end

    assign rd_value = rd_value_reg;
    assign rd_valid = rd_valid_reg;
    assign busy     = clearing_reg;

endmodule

// ===== src/fnv1a_hashed_slot_table_core.sv =====
// A word with key_last set gives its result in the cycle after acceptance.
// Throughput: one key byte per cycle while ready; the hash register folds each byte.
// A pending result that is not taken blocks only further input words.
// Reset (aresetn, synchronous, active low) restores the FNV offset basis and then
// clears all TABLE_DEPTH slot valid bits in one pass, with s_ready low.
module fnv1a_hashed_slot_table_core #(
    parameter int unsigned TABLE_DEPTH = fhst_pkg::DEFAULT_TABLE_DEPTH,
    parameter int unsigned VALUE_WIDTH = fhst_pkg::DEFAULT_VALUE_WIDTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fhst_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output fhst_pkg::out_word_t m_data
);
    import fhst_pkg::*;

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

    logic                   accept;
    logic                   finish;
    logic [HASH_W-1:0]      hash_now;
    slot_cmd_t              cmd;
    logic [VALUE_WIDTH-1:0] rd_value;
    logic                   rd_valid;
    logic                   busy;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [HASH_W-1:0]      hash_res_reg;
    op_t                    op_res_reg;
    logic                   hit;

    assign s_ready = !busy && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign finish  = accept && s_data.key_last;

    assign cmd.lookup = finish && (s_data.operation == OP_READ);
    assign cmd.insert = finish && (s_data.operation == OP_INSERT);

    fhst_hash_unit u_hash (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .key_byte (s_data.key_byte),
        .key_last (s_data.key_last),
        .hash_out (hash_now)
    );

    fhst_slot_store #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .addr     (hash_now[IDX_W-1:0]),
        .wr_value (VALUE_WIDTH'(s_data.insert_value)),
        .rd_value (rd_value),
        .rd_valid (rd_valid),
        .busy     (busy)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish) begin
            hash_res_reg <= hash_now;
            op_res_reg   <= s_data.operation;
        end
    end

    assign hit = (op_res_reg == OP_READ) && rd_valid;

    assign m_valid           = m_valid_reg;
    assign m_data.key_hash   = hash_res_reg;
    assign m_data.slot_index = SLOT_W'(hash_res_reg[IDX_W-1:0]);
    assign m_data.read_value = hit ? DATA_W'(rd_value) : '0;
    assign m_data.found      = hit;

    a_no_accept_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        busy |-> !s_ready)
        else $error("Input accepted during the valid-bit clearing pass.");

    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> m_valid)
        else $error("Final key byte did not produce a result.");

    a_insert_reports_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && op_res_reg == OP_INSERT) |-> (!m_data.found && m_data.read_value == '0))
        else $error("Insert result carries read data.");

    a_held_result_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("Input accepted while a result is stalled.");

endmodule

// ===== tb/sv/fhst_checker.sv =====
`timescale 1ns / 1ps

module fhst_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  fhst_pkg::in_word_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  fhst_pkg::out_word_t m_data,
    output int unsigned         mismatches,
    output int unsigned         outstanding
);
    import fhst_pkg::*;

    localparam int unsigned TABLE_DEPTH = DEFAULT_TABLE_DEPTH;
    localparam logic [HASH_W-1:0] FNV_PRIME = 64'd1099511628211;

    logic [HASH_W-1:0] key_hash_run;
    logic [DATA_W-1:0] slot_store [TABLE_DEPTH];
    logic              slot_used [TABLE_DEPTH];
    out_word_t         results_due [$];

    initial begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge aclk) begin
        out_word_t         due;
        out_word_t         got;
        logic [HASH_W-1:0] folded;
        logic [SLOT_W-1:0] slot;
        if (!aresetn) begin
            key_hash_run = FNV_BASIS;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                slot_used[i] = 1'b0;
            end
            results_due.delete();
            outstanding = 0;
        end else begin
            if (m_valid && m_ready) begin
                got = m_data;
                if (results_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("Unexpected result word: hash %h slot %h value %h found %b",
                                 got.key_hash, got.slot_index, got.read_value, got.found);
                    end
                end else begin
                    due = results_due.pop_front();
                    if (got.key_hash !== due.key_hash || got.slot_index !== due.slot_index ||
                        got.read_value !== due.read_value || got.found !== due.found) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Mismatch: expected hash %h slot %h value %h found %b",
                                     due.key_hash, due.slot_index, due.read_value, due.found);
                            $display("          actual   hash %h slot %h value %h found %b",
                                     got.key_hash, got.slot_index, got.read_value, got.found);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                folded = (key_hash_run ^ HASH_W'(s_data.key_byte)) * FNV_PRIME;
                if (!s_data.key_last) begin
                    key_hash_run = folded;
                end else begin
                    key_hash_run = FNV_BASIS;
                    slot = SLOT_W'(folded % HASH_W'(TABLE_DEPTH));
                    due = '0;
                    due.key_hash = folded;
                    due.slot_index = slot;
                    if (s_data.operation == OP_INSERT) begin
                        slot_store[slot] = s_data.insert_value;
                        slot_used[slot] = 1'b1;
                    end else if (slot_used[slot]) begin
                        due.read_value = slot_store[slot];
                        due.found = 1'b1;
                    end
                    results_due.push_back(due);
                end
            end
            outstanding = results_due.size();
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import fhst_pkg::*;

    localparam int unsigned STALL_LIMIT = 20000;
    localparam int unsigned WORD_TARGET = 1200;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned stall_cycles = 0;
    int unsigned words_sent = 0;
    bit          steady = 1'b0;

    logic [BYTE_W-1:0] key_buf [0:39];
    int unsigned       key_len;
    logic [BYTE_W-1:0] key_book [0:255][0:15];
    int unsigned       key_book_len [0:255];
    int unsigned       key_book_count = 0;

    always #4 aclk = ~aclk;

    fnv1a_hashed_slot_table_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    fhst_checker result_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 26);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(input in_word_t w);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 26) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
        words_sent++;
    endtask

    // Bytes before the last carry random operation and value, which the block must ignore.
    task automatic send_key(input op_t op, input logic [DATA_W-1:0] value);
        in_word_t    w;
        int unsigned idx;
        for (int unsigned i = 0; i < key_len; i++) begin
            w.operation = op_t'($urandom_range(0, 1));
            w.key_byte = key_buf[i];
            w.key_last = (i == key_len - 1);
            w.insert_value = $urandom();
            if (w.key_last) begin
                w.operation = op;
                w.insert_value = value;
            end
            send_word(w);
        end
        if (op == OP_INSERT && key_len <= 16) begin
            if (key_book_count < 256) begin
                idx = key_book_count;
                key_book_count++;
            end else begin
                idx = $urandom_range(0, 255);
            end
            key_book_len[idx] = key_len;
            for (int unsigned i = 0; i < key_len; i++) begin
                key_book[idx][i] = key_buf[i];
            end
        end
    endtask

    task automatic one_byte_key(input op_t op, input logic [BYTE_W-1:0] b,
                                input logic [DATA_W-1:0] value);
        key_len = 1;
        key_buf[0] = b;
        send_key(op, value);
    endtask

    task automatic fresh_key();
        key_len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < key_len; i++) begin
            key_buf[i] = $urandom_range(0, 255);
        end
    endtask

    task automatic known_key();
        int unsigned idx;
        idx = $urandom_range(0, key_book_count - 1);
        key_len = key_book_len[idx];
        for (int unsigned i = 0; i < key_len; i++) begin
            key_buf[i] = key_book[idx][i];
        end
    endtask

    initial begin
        int unsigned pick;
        bit          paused;
        in_word_t    w;
        paused = 1'b0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        one_byte_key(OP_READ, 8'h00, 32'hFFFF_FFFF);
        one_byte_key(OP_INSERT, 8'hFF, 32'hFFFF_FFFF);
        one_byte_key(OP_READ, 8'hFF, 32'h0000_0000);
        one_byte_key(OP_INSERT, 8'h00, 32'h0000_0000);
        one_byte_key(OP_READ, 8'h00, 32'hFFFF_FFFF);
        one_byte_key(OP_INSERT, 8'hFF, 32'h5A5A_A5A5);
        one_byte_key(OP_READ, 8'hFF, 32'h0000_0000);
        one_byte_key(OP_READ, 8'h80, 32'h1234_5678);
        key_len = 3;
        key_buf[0] = 8'h12;
        key_buf[1] = 8'h34;
        key_buf[2] = 8'h56;
        send_key(OP_INSERT, 32'h8000_0001);
        send_key(OP_READ, 32'h7FFF_FFFE);
        key_len = 4;
        key_buf[0] = 8'hFF;
        key_buf[1] = 8'h00;
        key_buf[2] = 8'hFF;
        key_buf[3] = 8'h00;
        send_key(OP_READ, 32'h0000_0000);

        while (words_sent < WORD_TARGET) begin
            steady = (words_sent >= 500 && words_sent < 700);
            if (!paused && words_sent >= 800) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                while (outstanding != 0) @(negedge aclk);
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w = {1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)), 32'($urandom())};
                send_word(w);
            end else if (pick < 45 && key_book_count > 0) begin
                known_key();
                send_key(OP_READ, $urandom());
            end else if (pick < 55 && key_book_count > 0) begin
                known_key();
                send_key(OP_INSERT, $urandom());
            end else if (pick < 70) begin
                fresh_key();
                send_key(OP_READ, $urandom());
            end else begin
                fresh_key();
                send_key(OP_INSERT, $urandom());
            end
        end
        steady = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (16) @(negedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
